// File: rtl/core/smp_pkg.sv
package smp_pkg;

    localparam int DATA_W       = 16;
    localparam int POW_W        = 32;
    localparam int BIN_W        = 7;
    localparam int BLEN_W       = 6;
    localparam int STEP_W       = 2;
    localparam int DIV_CNT_W    = 6;

    localparam logic [BIN_W-1:0]  TARGET_RESET  = 7'd51;
    localparam logic [STEP_W-1:0] NEWTON_LAST   = 2'd2;
    localparam logic [DATA_W-1:0] MAG_MAX       = 16'hFFFF;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic done;
    } t_div_stat;

endpackage

// File: rtl/core/smp_div.sv
module smp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smp_pkg::t_div_ctl             i_ctl,
    input  logic [smp_pkg::POW_W-1:0]     i_dividend,
    input  logic [smp_pkg::POW_W-1:0]     i_divisor,
    output smp_pkg::t_div_stat            o_stat,
    output logic [smp_pkg::POW_W-1:0]     o_quotient
);

    logic [smp_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_done, n_done;
    logic [smp_pkg::POW_W-1:0]     r_rem, n_rem;
    logic [smp_pkg::POW_W-1:0]     r_quo, n_quo;
    logic [smp_pkg::POW_W-1:0]     r_div, n_div;
    logic [smp_pkg::POW_W:0]       w_shift;
    logic [smp_pkg::POW_W+1:0]     w_diff;
    logic                          w_ge;

    assign w_shift = {r_rem, r_quo[smp_pkg::POW_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_ge    = ~w_diff[smp_pkg::POW_W+1];

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_ctl.start) begin
            n_cnt = smp_pkg::DIV_CNT_W'(smp_pkg::POW_W);
            n_rem = '0;
            n_quo = i_dividend;
            n_div = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - smp_pkg::DIV_CNT_W'(1);
            n_done = (r_cnt == smp_pkg::DIV_CNT_W'(1));
            n_rem  = w_ge ? w_diff[smp_pkg::POW_W-1:0] : w_shift[smp_pkg::POW_W-1:0];
            n_quo  = {r_quo[smp_pkg::POW_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// File: rtl/core/smp_root.sv
module smp_root (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [smp_pkg::DATA_W-1:0]    i_re_abs,
    input  logic [smp_pkg::DATA_W-1:0]    i_im_abs,
    output logic                          o_done,
    output logic [smp_pkg::DATA_W-1:0]    o_mag
);

    localparam logic [3:0] R_IDLE   = 4'd0;
    localparam logic [3:0] R_MUL_RE = 4'd1;
    localparam logic [3:0] R_MUL_IM = 4'd2;
    localparam logic [3:0] R_ADD    = 4'd3;
    localparam logic [3:0] R_BLEN   = 4'd4;
    localparam logic [3:0] R_SEED   = 4'd5;
    localparam logic [3:0] R_DSTART = 4'd6;
    localparam logic [3:0] R_DWAIT  = 4'd7;
    localparam logic [3:0] R_FIN    = 4'd8;

    logic [3:0]                        r_state, n_state;
    logic [smp_pkg::POW_W-1:0]         r_prod, n_prod;
    logic [smp_pkg::POW_W-1:0]         r_pow, n_pow;
    logic [smp_pkg::POW_W-1:0]         r_scan, n_scan;
    logic [smp_pkg::BLEN_W-1:0]        r_blen, n_blen;
    logic [smp_pkg::POW_W-1:0]         r_x, n_x;
    logic [smp_pkg::STEP_W-1:0]        r_step, n_step;
    logic [smp_pkg::DATA_W-1:0]        w_op;
    logic [smp_pkg::POW_W-1:0]         w_sum;
    logic [smp_pkg::POW_W:0]           w_newton;
    smp_pkg::t_div_ctl                 w_div_ctl;
    smp_pkg::t_div_stat                w_div_stat;
    logic [smp_pkg::POW_W-1:0]         w_quo;

    smp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (r_pow),
        .i_divisor  (r_x),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    assign w_op          = (r_state == R_MUL_RE) ? i_re_abs : i_im_abs;
    assign w_sum         = r_pow + r_prod;
    assign w_newton      = {1'b0, r_x} + {1'b0, w_quo};
    assign w_div_ctl.start = (r_state == R_DSTART) && (r_x != '0);

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_pow   = r_pow;
        n_scan  = r_scan;
        n_blen  = r_blen;
        n_x     = r_x;
        n_step  = r_step;
        case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    n_state = R_MUL_RE;
                end
            end
            R_MUL_RE: begin
                n_prod  = smp_pkg::POW_W'(w_op) * smp_pkg::POW_W'(w_op);
                n_state = R_MUL_IM;
            end
            R_MUL_IM: begin
                n_pow   = r_prod;
                n_prod  = smp_pkg::POW_W'(w_op) * smp_pkg::POW_W'(w_op);
                n_state = R_ADD;
            end
            R_ADD: begin
                n_pow   = w_sum;
                n_scan  = w_sum;
                n_blen  = '0;
                n_state = R_BLEN;
            end
            R_BLEN: begin
                if (r_scan != '0) begin
                    n_scan = r_scan >> 1;
                    n_blen = r_blen + smp_pkg::BLEN_W'(1);
                end else begin
                    n_state = R_SEED;
                end
            end
            R_SEED: begin
                n_step = '0;
                if (r_pow == '0) begin
                    n_x     = '0;
                    n_state = R_FIN;
                end else begin
                    n_x     = smp_pkg::POW_W'(1) << r_blen[smp_pkg::BLEN_W-1:1];
                    n_state = R_DSTART;
                end
            end
            R_DSTART: begin
                n_state = (r_x == '0) ? R_FIN : R_DWAIT;
            end
            R_DWAIT: begin
                if (w_div_stat.done) begin
                    n_x    = w_newton[smp_pkg::POW_W:1];
                    n_step = r_step + smp_pkg::STEP_W'(1);
                    n_state = (r_step == smp_pkg::NEWTON_LAST) ? R_FIN : R_DSTART;
                end
            end
            R_FIN: begin
                n_state = R_IDLE;
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_prod <= n_prod;
        r_pow  <= n_pow;
        r_scan <= n_scan;
        r_blen <= n_blen;
        r_x    <= n_x;
    end

    assign o_done = (r_state == R_FIN);
    assign o_mag  = (r_x > smp_pkg::POW_W'(smp_pkg::MAG_MAX)) ? smp_pkg::MAG_MAX
                                                              : r_x[smp_pkg::DATA_W-1:0];

endmodule

// File: rtl/core/spectrum_magnitude_peak_finder_top.sv
// Spectrum magnitude and peak finder.
// Input channel: i_in_valid / o_in_stall carry one FFT bin item (real and
// imaginary part). Bins are numbered internally 0..BINS-1 within a frame.
// Output channel: o_out_valid / i_out_stall carry one result item per bin:
// magnitude and bin index; on the last bin of a frame o_frame_end is high and
// the peak bin, peak value and target value are valid, zero otherwise.
// Configuration: i_cfg_valid / o_cfg_ready write the target bin; ready is
// always high, and writes are expected only while no item is in flight.
// Work per item: a zero power skips the Newton steps; otherwise the time grows
// with L, the bit length of the power: the scan shifts out one bit per step and
// each of the three Newton steps wraps a division in the single shared
// restoring divider.
// Flow: o_in_stall is high while an item is being worked on, so no new item
// is taken before the last result is loaded; the next item can be taken in
// the cycle after that load. A finished result sits in the output register,
// so the next item is accepted while it waits. If the receiver stalls, the
// result holds and a following result waits inside the block until the
// output register frees.
// Reset (synchronous, active low) empties both sides, clears the frame
// state and the bin counter, and sets the target bin to 51.
module spectrum_magnitude_peak_finder_top #(
    parameter int BINS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [smp_pkg::DATA_W-1:0] i_real_part,
    input  logic signed [smp_pkg::DATA_W-1:0] i_imag_part,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [smp_pkg::DATA_W-1:0]        o_magnitude,
    output logic [smp_pkg::BIN_W-1:0]         o_bin_index,
    output logic                              o_frame_end,
    output logic [smp_pkg::BIN_W-1:0]         o_peak_bin,
    output logic [smp_pkg::DATA_W-1:0]        o_peak_value,
    output logic [smp_pkg::DATA_W-1:0]        o_target_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [smp_pkg::BIN_W-1:0]         i_cfg_watch_bin
);

    localparam int CW = (BINS > 2) ? $clog2(BINS) : 1;
    localparam int XW = CW + smp_pkg::BIN_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [smp_pkg::DATA_W-1:0]        r_re_abs, r_im_abs;
    logic [smp_pkg::DATA_W-1:0]        r_mag;
    logic [smp_pkg::BIN_W-1:0]         r_target;
    logic [CW-1:0]                     r_cnt;
    logic [smp_pkg::DATA_W-1:0]        r_best_mag, n_best_mag;
    logic [smp_pkg::BIN_W-1:0]         r_best_bin, n_best_bin;
    logic [smp_pkg::DATA_W-1:0]        r_tgt_mag, n_tgt_mag;
    logic                              r_out_valid;
    logic                              w_accept, w_load, w_last, w_hit;
    logic                              w_root_done;
    logic [smp_pkg::DATA_W-1:0]        w_root_mag;
    logic [XW-1:0]                     w_cnt_x;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_load      = (r_state == ST_WAIT) && (!r_out_valid || !i_out_stall);
    assign w_cnt_x     = {{smp_pkg::BIN_W{1'b0}}, r_cnt};
    assign w_last      = (r_cnt == CW'(BINS - 1));
    assign w_hit       = (w_cnt_x == {{CW{1'b0}}, r_target});

    smp_root u_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == ST_CALC),
        .i_re_abs (r_re_abs),
        .i_im_abs (r_im_abs),
        .o_done   (w_root_done),
        .o_mag    (w_root_mag)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (w_root_done) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_best_mag = r_best_mag;
        n_best_bin = r_best_bin;
        n_tgt_mag  = r_tgt_mag;
        if ((r_cnt != '0) && (r_mag > r_best_mag)) begin
            n_best_mag = r_mag;
            n_best_bin = w_cnt_x[smp_pkg::BIN_W-1:0];
        end
        if (w_hit) begin
            n_tgt_mag = r_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= smp_pkg::TARGET_RESET;
            r_cnt       <= '0;
            r_best_mag  <= '0;
            r_best_bin  <= '0;
            r_tgt_mag   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_watch_bin;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (w_last) begin
                    r_cnt      <= '0;
                    r_best_mag <= '0;
                    r_best_bin <= '0;
                    r_tgt_mag  <= '0;
                end else begin
                    r_cnt      <= r_cnt + CW'(1);
                    r_best_mag <= n_best_mag;
                    r_best_bin <= n_best_bin;
                    r_tgt_mag  <= n_tgt_mag;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_re_abs <= i_real_part[smp_pkg::DATA_W-1] ? -i_real_part : i_real_part;
            r_im_abs <= i_imag_part[smp_pkg::DATA_W-1] ? -i_imag_part : i_imag_part;
        end
        if (w_root_done) begin
            r_mag <= w_root_mag;
        end
        if (w_load) begin
            o_magnitude    <= r_mag;
            o_bin_index    <= w_cnt_x[smp_pkg::BIN_W-1:0];
            o_frame_end    <= w_last;
            o_peak_bin     <= w_last ? n_best_bin : '0;
            o_peak_value   <= w_last ? n_best_mag : '0;
            o_target_value <= w_last ? n_tgt_mag : '0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/smp_chk.sv
module smp_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic signed [smp_pkg::DATA_W-1:0] i_real_part,
    input  logic signed [smp_pkg::DATA_W-1:0] i_imag_part,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [smp_pkg::DATA_W-1:0]        o_magnitude,
    input  logic [smp_pkg::BIN_W-1:0]         o_bin_index,
    input  logic                              o_frame_end,
    input  logic [smp_pkg::BIN_W-1:0]         o_peak_bin,
    input  logic [smp_pkg::DATA_W-1:0]        o_peak_value,
    input  logic [smp_pkg::DATA_W-1:0]        o_target_value,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [smp_pkg::BIN_W-1:0]         i_cfg_watch_bin
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_magnitude) && $stable(o_bin_index)
            && $stable(o_frame_end) && $stable(o_target_value))
        else $error("stalled result item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("input taken again while an item is in work");

    a_mid_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_end |-> (o_peak_bin == '0) && (o_peak_value == '0)
            && (o_target_value == '0))
        else $error("frame summary shown on a bin that does not end the frame");

endmodule

bind spectrum_magnitude_peak_finder_top smp_chk u_smp_chk (.*);

// File: sim/tb_spectrum_magnitude_peak_finder_top.sv
`timescale 1ns / 1ps

module tb_spectrum_magnitude_peak_finder_top;

    localparam int BINS           = 128;
    localparam int ITEMS          = 900;
    localparam int HOLD_CYCLES    = 2000;
    localparam int HOLD_AFTER     = 200;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int END_WAIT       = 300;

    typedef struct {
        logic [smp_pkg::DATA_W-1:0] magnitude;
        logic [smp_pkg::BIN_W-1:0]  bin_index;
        logic                       frame_end;
        logic [smp_pkg::BIN_W-1:0]  peak_bin;
        logic [smp_pkg::DATA_W-1:0] peak_value;
        logic [smp_pkg::DATA_W-1:0] target_value;
    } t_bin_result;

    typedef enum int {PICK_FULL, PICK_LOW, PICK_CORNER, PICK_ZERO} t_pick;

    class t_spectrum_tracker;
        t_bin_result                expected_bins[$];
        logic [smp_pkg::BIN_W-1:0]  watch_bin;
        int unsigned                bin_counter;
        logic [smp_pkg::DATA_W-1:0] best_mag;
        logic [smp_pkg::BIN_W-1:0]  best_bin;
        logic [smp_pkg::DATA_W-1:0] target_mag;
        int                         errors;

        function new();
            watch_bin   = smp_pkg::TARGET_RESET;
            bin_counter = 0;
            best_mag    = '0;
            best_bin    = '0;
            target_mag  = '0;
            errors      = 0;
        endfunction

        function void set_target(logic [smp_pkg::BIN_W-1:0] value);
            watch_bin = value;
        endfunction

        function int pending();
            return expected_bins.size();
        endfunction

        function logic [smp_pkg::DATA_W-1:0] newton_root(int unsigned p);
            int unsigned x;
            int unsigned t;
            int          n;
            if (p == 0) return '0;
            n = 0;
            t = p;
            while (t != 0) begin
                n++;
                t = t >> 1;
            end
            x = 32'd1 << (n / 2);
            repeat (3) begin
                if (x == 0) return '0;
                x = (x + p / x) / 2;
            end
            if (x > 32'hFFFF) x = 32'hFFFF;
            return x[smp_pkg::DATA_W-1:0];
        endfunction

        function void note_bin(logic signed [smp_pkg::DATA_W-1:0] re,
                               logic signed [smp_pkg::DATA_W-1:0] im);
            int unsigned a;
            int unsigned b;
            int unsigned k;
            t_bin_result r;
            a = re[smp_pkg::DATA_W-1] ? (32'd65536 - {16'd0, re}) : {16'd0, re};
            b = im[smp_pkg::DATA_W-1] ? (32'd65536 - {16'd0, im}) : {16'd0, im};
            r.magnitude = newton_root(a * a + b * b);
            k = (bin_counter >= BINS) ? 0 : bin_counter;
            if (k != 0 && r.magnitude > best_mag) begin
                best_mag = r.magnitude;
                best_bin = k[smp_pkg::BIN_W-1:0];
            end
            if (k == {25'd0, watch_bin}) target_mag = r.magnitude;
            r.bin_index = k[smp_pkg::BIN_W-1:0];
            r.frame_end = (k == BINS - 1);
            if (r.frame_end) begin
                r.peak_bin     = best_bin;
                r.peak_value   = best_mag;
                r.target_value = target_mag;
                best_mag    = '0;
                best_bin    = '0;
                target_mag  = '0;
                bin_counter = 0;
            end else begin
                r.peak_bin     = '0;
                r.peak_value   = '0;
                r.target_value = '0;
                bin_counter    = k + 1;
            end
            expected_bins.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_bin(logic [smp_pkg::DATA_W-1:0] magnitude,
                                logic [smp_pkg::BIN_W-1:0] bin_index,
                                logic frame_end, logic [smp_pkg::BIN_W-1:0] peak_bin,
                                logic [smp_pkg::DATA_W-1:0] peak_value,
                                logic [smp_pkg::DATA_W-1:0] target_value);
            t_bin_result want;
            if (expected_bins.size() == 0) begin
                $error("result with no item outstanding: bin_index %0d", bin_index);
                errors++;
                return;
            end
            want = expected_bins.pop_front();
            compare_field("magnitude", want.magnitude, magnitude);
            compare_field("bin_index", want.bin_index, bin_index);
            compare_field("frame_end", want.frame_end, frame_end);
            compare_field("peak_bin", want.peak_bin, peak_bin);
            compare_field("peak_value", want.peak_value, peak_value);
            compare_field("target_value", want.target_value, target_value);
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic signed [smp_pkg::DATA_W-1:0] i_real_part;
    logic signed [smp_pkg::DATA_W-1:0] i_imag_part;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [smp_pkg::DATA_W-1:0]        o_magnitude;
    logic [smp_pkg::BIN_W-1:0]         o_bin_index;
    logic                              o_frame_end;
    logic [smp_pkg::BIN_W-1:0]         o_peak_bin;
    logic [smp_pkg::DATA_W-1:0]        o_peak_value;
    logic [smp_pkg::DATA_W-1:0]        o_target_value;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [smp_pkg::BIN_W-1:0]         i_cfg_watch_bin;

    t_spectrum_tracker                 tracker = new();
    int                                items_sent = 0;
    int                                results_seen = 0;
    int                                burst_left = 0;
    int                                quiet_cycles = 0;
    bit                                rx_hold = 1'b0;
    logic signed [smp_pkg::DATA_W-1:0] last_re = '0;
    logic signed [smp_pkg::DATA_W-1:0] last_im = '0;

    spectrum_magnitude_peak_finder_top #(
        .BINS(BINS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_real_part      (i_real_part),
        .i_imag_part      (i_imag_part),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_magnitude      (o_magnitude),
        .o_bin_index      (o_bin_index),
        .o_frame_end      (o_frame_end),
        .o_peak_bin       (o_peak_bin),
        .o_peak_value     (o_peak_value),
        .o_target_value   (o_target_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_watch_bin  (i_cfg_watch_bin)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_pick pick_how();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return PICK_FULL;
        if (roll < 75) return PICK_LOW;
        if (roll < 90) return PICK_CORNER;
        return PICK_ZERO;
    endfunction

    function automatic logic signed [smp_pkg::DATA_W-1:0] pick_part(t_pick how);
        logic [31:0] v;
        case (how)
            PICK_FULL: begin
                v = $urandom_range(0, 65535);
            end
            PICK_LOW: begin
                v = $urandom_range(0, 16) - 8;
            end
            PICK_CORNER: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000;
                    1:       v = 32'hFFFF;
                    2:       v = 32'h0001;
                    3:       v = 32'h7FFF;
                    default: v = 32'h0000;
                endcase
            end
            default: begin
                v = '0;
            end
        endcase
        return v[smp_pkg::DATA_W-1:0];
    endfunction

    task automatic feed_bin(logic signed [smp_pkg::DATA_W-1:0] re,
                            logic signed [smp_pkg::DATA_W-1:0] im);
        int gap;
        i_real_part <= re;
        i_imag_part <= im;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_bin(re, im);
        items_sent++;
        last_re = re;
        last_im = im;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = (rx_hold || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(0, 11);
        end
    endtask

    task automatic random_bin();
        if ($urandom_range(0, 9) == 0) begin
            feed_bin(last_re, last_im);
        end else begin
            feed_bin(pick_part(pick_how()), pick_part(pick_how()));
        end
    endtask

    task automatic drain_pending();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_target(logic [smp_pkg::BIN_W-1:0] value);
        i_cfg_watch_bin <= value;
        i_cfg_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_target(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_bin(o_magnitude, o_bin_index, o_frame_end, o_peak_bin,
                              o_peak_value, o_target_value);
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : receiver
        int  run_len;
        int  style;
        bit  held;
        held = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            style   = $urandom_range(0, 2);
            run_len = $urandom_range(10, 400);
            repeat (run_len) begin
                @(negedge i_clk);
                if (!held && results_seen >= HOLD_AFTER) begin
                    held    = 1'b1;
                    rx_hold = 1'b1;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    rx_hold = 1'b0;
                end
                case (style)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 1) == 0);
                    default: i_out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [smp_pkg::BIN_W-1:0] tgt;
        int                        count;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_real_part      <= '0;
        i_imag_part      <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_watch_bin  <= '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bin 0 carries the largest power and must stay out of the peak
        feed_bin(16'sh8000, 16'sh8000);
        feed_bin(16'sh0000, 16'sh0000);
        feed_bin(16'sh7FFF, 16'sh7FFF);
        feed_bin(16'sh8000, 16'sh0000);
        feed_bin(16'sh0000, 16'sh8000);
        feed_bin(16'sh7FFF, 16'sh8000);
        feed_bin(16'sh0001, 16'sh0000);
        feed_bin(16'shFFFF, 16'shFFFF);
        feed_bin(16'sh0003, 16'sh0004);
        feed_bin(16'sh8000, 16'sh8000);
        feed_bin(16'sh8000, 16'sh8000);
        feed_bin(16'sh0000, 16'sh0001);
        feed_bin(16'sh00FF, 16'shFF00);
        feed_bin(16'shAAAA, 16'sh3039);
        feed_bin(16'sh4000, 16'sh0000);
        feed_bin(16'sh0000, 16'sh0000);
        feed_bin(16'sh7FFF, 16'sh0000);
        feed_bin(16'shFFFF, 16'sh0000);
        feed_bin(16'sh5555, 16'shAAAA);
        feed_bin(16'shFFFF, 16'sh7FFF);
        while (items_sent < BINS) random_bin();

        // a frame with no power at all
        drain_pending();
        write_target('0);
        repeat (BINS) feed_bin('0, '0);

        drain_pending();
        write_target({smp_pkg::BIN_W{1'b1}});
        repeat (BINS) random_bin();

        while (items_sent < ITEMS) begin
            drain_pending();
            case ($urandom_range(0, 5))
                0:       tgt = '0;
                1:       tgt = {smp_pkg::BIN_W{1'b1}};
                2:       tgt = smp_pkg::TARGET_RESET;
                default: tgt = smp_pkg::BIN_W'($urandom_range(0, BINS - 1));
            endcase
            write_target(tgt);
            count = $urandom_range(40, 200);
            if (count > ITEMS - items_sent) count = ITEMS - items_sent;
            repeat (count) random_bin();
        end

        drain_pending();
        repeat (END_WAIT) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
